// ===== sv/boolean_formula_truth_table_assert.svh =====
// ----------------------------------------------------------------------------
// boolean_formula_truth_table_assert
// Assertion macros used by the checker of this block. Each macro
// takes a label, an antecedent, a consequent and a message.
// ----------------------------------------------------------------------------
`ifndef BOOLEAN_FORMULA_TRUTH_TABLE_ASSERT_SVH
`define BOOLEAN_FORMULA_TRUTH_TABLE_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge out of reset
`define BFT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define BFT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/bft_pkg.sv =====
// ----------------------------------------------------------------------------
// bft_pkg
// Shared types, codes and word functions of the truth-table formula evaluator.
// ----------------------------------------------------------------------------
package bft_pkg;

  localparam int TT_W            = 64;
  localparam int NV_W            = 3;
  localparam int MAX_VARS        = 6;
  localparam int STACK_DEPTH_DEF = 32;

  // Token kinds; codes five to seven are treated like an open token
  typedef enum logic [2:0] {
    KIND_OPEN  = 3'd0,
    KIND_VAR   = 3'd1,
    KIND_CONST = 3'd2,
    KIND_CLOSE = 3'd3,
    KIND_OPER  = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    OP_OR    = 3'd0,
    OP_AND   = 3'd1,
    OP_IMPL  = 3'd2,
    OP_EQUIV = 3'd3,
    OP_XOR   = 3'd4,
    OP_NAND  = 3'd5,
    OP_NOR   = 3'd6,
    OP_NOT   = 3'd7
  } op_t;

  // Operator stack command
  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } ostk_cmd_t;

  // Value stack command
  typedef struct packed {
    logic push;
    logic unary;
    logic binary;
    logic clear;
  } vstk_cmd_t;

  // Truth-table word of a variable whose bit is taken at position sh of i
  function automatic logic [TT_W-1:0] var_word(input logic [NV_W-1:0] sh);
    logic [TT_W-1:0] w;
    case (sh)
      3'd0:    w = 64'hAAAA_AAAA_AAAA_AAAA;
      3'd1:    w = 64'hCCCC_CCCC_CCCC_CCCC;
      3'd2:    w = 64'hF0F0_F0F0_F0F0_F0F0;
      3'd3:    w = 64'hFF00_FF00_FF00_FF00;
      3'd4:    w = 64'hFFFF_0000_FFFF_0000;
      3'd5:    w = 64'hFFFF_FFFF_0000_0000;
      default: w = '0;
    endcase
    return w;
  endfunction

  // Mask of the 2^n valid table bits
  function automatic logic [TT_W-1:0] table_mask(input logic [NV_W-1:0] n);
    logic [TT_W-1:0] m;
    case (n)
      3'd0:    m = 64'h0000_0000_0000_0001;
      3'd1:    m = 64'h0000_0000_0000_0003;
      3'd2:    m = 64'h0000_0000_0000_000F;
      3'd3:    m = 64'h0000_0000_0000_00FF;
      3'd4:    m = 64'h0000_0000_0000_FFFF;
      3'd5:    m = 64'h0000_0000_FFFF_FFFF;
      default: m = '1;
    endcase
    return m;
  endfunction

  // Apply a two-operand operator; a is the lower stack entry
  function automatic logic [TT_W-1:0] combine(input logic [TT_W-1:0] a,
                                              input logic [TT_W-1:0] b,
                                              input op_t             op);
    logic [TT_W-1:0] r;
    case (op)
      OP_OR:    r = a | b;
      OP_AND:   r = a & b;
      OP_IMPL:  r = ~a | b;
      OP_EQUIV: r = ~(a ^ b);
      OP_XOR:   r = a ^ b;
      OP_NAND:  r = ~(a & b);
      default:  r = ~(a | b);
    endcase
    return r;
  endfunction

endpackage

// ===== sv/boolean_formula_truth_table.sv =====
// ----------------------------------------------------------------------------
// boolean_formula_truth_table
// Evaluates a fully parenthesized Boolean formula over all variable
// assignments at once, one token per transfer, with a sticky error flag.
// ----------------------------------------------------------------------------
//  Channel | Direction | tdata                                      | tuser / tlast
//  in_     | slave     | [2:0] var_index [3] const_value            | tuser: token_kind
//          |           | [6:4] operator_code [7] zero               | tlast: last_token
//  out_    | master    | [63:0] truth_table                         | tuser: error
//  cfg_    | slave     | [2:0] num_vars                             | -
//
//  One token per cycle while in_tready is high; every token finishes in the cycle it is transferred.
//  Deeper stack entries come from a RAM with registered read data, prefetched
//  one below the registered top entries, so a pop never waits on the RAM.
//  The result of a last token is registered and shown on the next cycle.
//  Input stalls only while a result waits and out_tready is low.
//  Reset clears counts and flags at once; the RAMs need no clearing pass.
// ----------------------------------------------------------------------------
module boolean_formula_truth_table
  import bft_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  // Token input
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [7:0]      in_tdata,   // [2:0] var_index, [3] const_value,
                                      // [6:4] operator_code, [7] zero
  input  logic [2:0]      in_tuser,   // [2:0] token_kind
  input  logic            in_tlast,   // last_token
  // Result output
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [TT_W-1:0] out_tdata,  // [63:0] truth_table
  output logic            out_tuser,  // [0] error
  // Configuration
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [NV_W-1:0] cfg_data    // [2:0] num_vars
);

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);

  logic [NV_W-1:0]  num_vars_r, n_eff, var_index, var_sh;
  logic             err_r, err_nxt, err_now;
  logic             out_valid_r, out_valid_nxt;
  logic [TT_W-1:0]  out_data_r, out_data_nxt;
  logic             out_err_r, out_err_nxt;
  logic             accept, bad_var, err_final;
  kind_t            kind;
  op_t              in_op, op_top;
  ostk_cmd_t        ocmd;
  vstk_cmd_t        vcmd;
  logic [TT_W-1:0]  push_word, top_aft;
  logic [CNT_W-1:0] vcnt, vcnt_aft, ocnt;

  assign in_tready = !out_valid_r || out_tready;
  assign cfg_ready = 1'b1;
  assign accept    = in_tvalid && in_tready;
  assign kind      = kind_t'(in_tuser);
  assign var_index = in_tdata[2:0];
  assign in_op     = op_t'(in_tdata[6:4]);
  assign n_eff     = (num_vars_r > NV_W'(MAX_VARS)) ? NV_W'(MAX_VARS) : num_vars_r;
  assign bad_var   = (var_index == '0) || (var_index > n_eff);
  assign var_sh    = n_eff - var_index;

  // Decode the token into stack commands and errors
  always_comb begin
    ocmd      = '0;
    vcmd      = '0;
    err_now   = 1'b0;
    push_word = '0;
    case (kind)
      KIND_VAR: begin
        push_word = bad_var ? '0 : var_word(var_sh);
        err_now   = bad_var;
        if (vcnt == CNT_W'(STACK_DEPTH)) begin
          err_now = 1'b1;
        end else begin
          vcmd.push = 1'b1;
        end
      end
      KIND_CONST: begin
        push_word = {TT_W{in_tdata[3]}};
        if (vcnt == CNT_W'(STACK_DEPTH)) begin
          err_now = 1'b1;
        end else begin
          vcmd.push = 1'b1;
        end
      end
      KIND_CLOSE: begin
        if (ocnt == '0) begin
          err_now = 1'b1;
        end else begin
          ocmd.pop = 1'b1;
          if (op_top == OP_NOT) begin
            if (vcnt == '0) begin
              err_now = 1'b1;
            end else begin
              vcmd.unary = 1'b1;
            end
          end else if (vcnt < CNT_W'(2)) begin
            err_now = 1'b1;
          end else begin
            vcmd.binary = 1'b1;
          end
        end
      end
      KIND_OPER: begin
        if (ocnt == CNT_W'(STACK_DEPTH)) begin
          err_now = 1'b1;
        end else begin
          ocmd.push = 1'b1;
        end
      end
      default: ;
    endcase
    // Drop everything unless a token is transferred
    if (!accept) begin
      ocmd    = '0;
      vcmd    = '0;
      err_now = 1'b0;
    end
    ocmd.clear = accept && in_tlast;
    vcmd.clear = accept && in_tlast;
  end

  bft_ostack #(.DEPTH(STACK_DEPTH)) u_ostack (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (ocmd),
    .push_code (in_op),
    .top_code  (op_top),
    .count     (ocnt)
  );

  bft_vstack #(.DEPTH(STACK_DEPTH)) u_vstack (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (vcmd),
    .push_word (push_word),
    .op        (op_top),
    .count     (vcnt),
    .top_aft   (top_aft),
    .count_aft (vcnt_aft)
  );

  // Build the result on the last token; clear the sticky error after it
  always_comb begin
    err_final     = err_r || err_now || (vcnt_aft == '0);
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_err_nxt   = out_err_r;
    err_nxt       = err_r || err_now;
    if (accept && in_tlast) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = (vcnt_aft == '0) ? '0 : (top_aft & table_mask(n_eff));
      out_err_nxt   = err_final;
      err_nxt       = 1'b0;
    end
  end

  // Advance control and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_vars_r  <= '0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        num_vars_r <= cfg_data;
      end
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
    out_err_r  <= out_err_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_err_r;

endmodule

// ===== sv/bft_ram.sv =====
// ----------------------------------------------------------------------------
// bft_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bft_ram #(
  parameter  int W     = 8,
  parameter  int DEPTH = 32,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [W-1:0]  wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [W-1:0]  rd_data
);

  logic [W-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== sv/bft_ostack.sv =====
// ----------------------------------------------------------------------------
// bft_ostack
// Operator stack: top code in a register, deeper entries in a RAM that is
// prefetched at the entry just below the top, with write forwarding.
// ----------------------------------------------------------------------------
module bft_ostack
  import bft_pkg::*;
#(
  parameter  int DEPTH = STACK_DEPTH_DEF,
  localparam int CNT_W = $clog2(DEPTH + 1),
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  ostk_cmd_t        cmd,
  input  op_t              push_code,
  output op_t              top_code,
  output logic [CNT_W-1:0] count
);

  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_aft, rd_tmp;
  op_t              top_r, top_nxt;
  logic             fwd_hit_r, fwd_hit_nxt;
  op_t              fwd_data_r;
  logic             wr_en;
  logic [AW-1:0]    wr_addr, rd_addr;
  logic [2:0]       rd_data;
  op_t              below;

  assign below = fwd_hit_r ? fwd_data_r : op_t'(rd_data);

  // Push spills the old top; pop takes the prefetched entry below
  always_comb begin
    cnt_aft = cnt_r;
    top_nxt = top_r;
    wr_en   = 1'b0;
    wr_addr = AW'(cnt_r - CNT_W'(1));
    if (cmd.push) begin
      top_nxt = push_code;
      cnt_aft = cnt_r + CNT_W'(1);
      wr_en   = (cnt_r != '0);
    end else if (cmd.pop) begin
      top_nxt = below;
      cnt_aft = cnt_r - CNT_W'(1);
    end
    cnt_nxt     = cmd.clear ? '0 : cnt_aft;
    rd_tmp      = cnt_nxt - CNT_W'(2);
    rd_addr     = rd_tmp[AW-1:0];
    fwd_hit_nxt = wr_en && (wr_addr == rd_addr);
  end

  bft_ram #(.W(3), .DEPTH(DEPTH)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (top_r),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Hold count and forwarding flag; top and forwarded data need no reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      fwd_hit_r <= 1'b0;
    end else begin
      cnt_r     <= cnt_nxt;
      fwd_hit_r <= fwd_hit_nxt;
    end
    top_r      <= top_nxt;
    fwd_data_r <= top_r;
  end

  assign top_code = top_r;
  assign count    = cnt_r;

endmodule

// ===== sv/bft_vstack.sv =====
// ----------------------------------------------------------------------------
// bft_vstack
// Value stack of truth-table words: top two entries in registers, deeper
// entries in a RAM prefetched at the third entry, with write forwarding.
// ----------------------------------------------------------------------------
module bft_vstack
  import bft_pkg::*;
#(
  parameter  int DEPTH = STACK_DEPTH_DEF,
  localparam int CNT_W = $clog2(DEPTH + 1),
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  vstk_cmd_t        cmd,
  input  logic [TT_W-1:0]  push_word,
  input  op_t              op,
  output logic [CNT_W-1:0] count,
  output logic [TT_W-1:0]  top_aft,
  output logic [CNT_W-1:0] count_aft
);

  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_aft, rd_tmp;
  logic [TT_W-1:0]  top_r, sec_r, sec_nxt, top_nxt;
  logic             fwd_hit_r, fwd_hit_nxt;
  logic [TT_W-1:0]  fwd_data_r;
  logic             wr_en;
  logic [AW-1:0]    wr_addr, rd_addr;
  logic [TT_W-1:0]  rd_data, below;

  assign below = fwd_hit_r ? fwd_data_r : rd_data;

  // Update the top two words; spill the second on push, refill it on combine
  always_comb begin
    cnt_aft = cnt_r;
    top_nxt = top_r;
    sec_nxt = sec_r;
    wr_en   = 1'b0;
    wr_addr = AW'(cnt_r - CNT_W'(2));
    if (cmd.push) begin
      top_nxt = push_word;
      sec_nxt = top_r;
      cnt_aft = cnt_r + CNT_W'(1);
      wr_en   = (cnt_r >= CNT_W'(2));
    end else if (cmd.unary) begin
      top_nxt = ~top_r;
    end else if (cmd.binary) begin
      top_nxt = combine(sec_r, top_r, op);
      sec_nxt = below;
      cnt_aft = cnt_r - CNT_W'(1);
    end
    cnt_nxt     = cmd.clear ? '0 : cnt_aft;
    rd_tmp      = cnt_nxt - CNT_W'(3);
    rd_addr     = rd_tmp[AW-1:0];
    fwd_hit_nxt = wr_en && (wr_addr == rd_addr);
  end

  bft_ram #(.W(TT_W), .DEPTH(DEPTH)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (sec_r),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Hold count and forwarding flag; words need no reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      fwd_hit_r <= 1'b0;
    end else begin
      cnt_r     <= cnt_nxt;
      fwd_hit_r <= fwd_hit_nxt;
    end
    top_r      <= top_nxt;
    sec_r      <= sec_nxt;
    fwd_data_r <= sec_r;
  end

  assign count     = cnt_r;
  assign top_aft   = top_nxt;
  assign count_aft = cnt_aft;

endmodule

// ===== sv/bft_checker.sv =====
// ----------------------------------------------------------------------------
// bft_checker
// Port-level checks of the truth-table evaluator, bound to the top level.
// ----------------------------------------------------------------------------
`include "boolean_formula_truth_table_assert.svh"

module bft_checker
  import bft_pkg::*;
(
  input logic            clk,
  input logic            rst_n,
  input logic            in_tvalid,
  input logic            in_tready,
  input logic            in_tlast,
  input logic            out_tvalid,
  input logic            out_tready,
  input logic [TT_W-1:0] out_tdata,
  input logic            out_tuser
);

  // A stalled result holds
  `BFT_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

  // A new result follows only a last-token transfer
  `BFT_ASSERT_NOW(a_out_cause, $rose(out_tvalid), $past(in_tvalid && in_tready && in_tlast), "result without last token")

  // A non-last token never produces a result
  `BFT_ASSERT_NEXT(a_no_spurious, in_tvalid && in_tready && !in_tlast && (!out_tvalid || out_tready), !out_tvalid, "result from non-last token")

  // Input backpressure only while a result is stalled
  `BFT_ASSERT_NOW(a_in_stall, !in_tready, out_tvalid && !out_tready, "input stalled without cause")

endmodule

bind boolean_formula_truth_table bft_checker u_bft_checker (.*);

// ===== sim/tb_boolean_formula_truth_table.sv =====
// ----------------------------------------------------------------------------
// tb_boolean_formula_truth_table
// Self-checking bench for the truth-table formula evaluator. A queue of
// formula tokens and num_vars writes feeds a stream driver. A cycle-level
// predictor keeps its own value and operator stacks and queues one table per
// last token. The monitor checks every result transfer against the oldest
// queued table. Random gaps are placed on both sides of the block.
// ----------------------------------------------------------------------------
module tb_boolean_formula_truth_table;
  import bft_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SDEPTH      = STACK_DEPTH_DEF;
  localparam int SETTLE      = 4;
  localparam int TAIL        = 20;
  localparam int PHASE_ITEMS = 140;
  localparam int CYCLE_LIMIT = 400000;

  // Kind code outside the defined set, ignored like an open token
  localparam logic [2:0] KIND_SPARE = 3'd6;

  // Plan codes of the formula generator; values >= 0 are subformula depths
  localparam int PLAN_OPEN  = -1;
  localparam int PLAN_CLOSE = -2;
  localparam int PLAN_OPER  = -10;

  typedef struct packed {
    logic       is_cfg;
    logic [2:0] cfg_val;
    logic [2:0] kind;
    logic [2:0] vidx;
    logic       cval;
    logic [2:0] opc;
    logic       last;
  } stim_t;

  typedef struct packed {
    logic [TT_W-1:0] tt;
    logic            err;
  } table_res_t;

  // DUT signals
  logic            clk        = 1'b0;
  logic            rst_n      = 1'b0;
  logic            in_tvalid  = 1'b0;
  logic            in_tready;
  logic [7:0]      in_tdata   = '0;
  logic [2:0]      in_tuser   = '0;
  logic            in_tlast   = 1'b0;
  logic            out_tvalid;
  logic            out_tready = 1'b0;
  logic [TT_W-1:0] out_tdata;
  logic            out_tuser;
  logic            cfg_valid  = 1'b0;
  logic            cfg_ready;
  logic [NV_W-1:0] cfg_data   = '0;

  // Stimulus and bookkeeping
  stim_t      pending[$];
  stim_t      draft[$];
  table_res_t due_tables[$];
  int         live_cnt   = 0;
  int         tok_issued = 0;
  int         tok_taken  = 0;
  int         cfg_issued = 0;
  int         cfg_taken  = 0;
  int         res_taken  = 0;
  int         fault_cnt  = 0;
  int         cycle_cnt  = 0;

  // Predictor state
  logic [TT_W-1:0] words[SDEPTH];
  op_t             op_stk[SDEPTH];
  int              word_cnt  = 0;
  int              op_cnt    = 0;
  logic            err_seen  = 1'b0;
  logic [NV_W-1:0] nvars     = '0;

  boolean_formula_truth_table u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // Clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("** boolean_formula_truth_table: FAILED **");
      $finish;
    end
  end

  task automatic flag_fault(input string what, input logic [TT_W-1:0] want,
                            input logic [TT_W-1:0] got);
    fault_cnt++;
    if (fault_cnt <= 10)
      $display("mismatch %0d: %s expected %h got %h", fault_cnt, what, want, got);
  endtask

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  task automatic push_word(input logic [TT_W-1:0] w);
    if (word_cnt >= SDEPTH) begin
      err_seen = 1'b1;
    end else begin
      words[word_cnt] = w;
      word_cnt++;
    end
  endtask

  task automatic eval_token(input logic [2:0] kind, input logic [2:0] vidx,
                            input logic cval, input logic [2:0] opc, input logic last);
    logic [TT_W-1:0] w;
    logic [TT_W-1:0] a;
    logic [TT_W-1:0] b;
    logic [TT_W-1:0] mask;
    table_res_t      r;
    op_t             op;
    int              neff;
    neff = (nvars > MAX_VARS) ? MAX_VARS : nvars;
    w = '0;
    case (kind)
      KIND_VAR: begin
        // Variable k follows bit (n-k) of the assignment index
        if (vidx == 0 || vidx > neff) begin
          err_seen = 1'b1;
        end else begin
          for (int i = 0; i < TT_W; i++)
            w[i] = 1'((i >> (neff - int'(vidx))) & 1);
        end
        push_word(w);
      end
      KIND_CONST: begin
        push_word(cval ? {TT_W{1'b1}} : {TT_W{1'b0}});
      end
      KIND_CLOSE: begin
        if (op_cnt == 0) begin
          err_seen = 1'b1;
        end else begin
          op_cnt--;
          op = op_stk[op_cnt];
          if (op == OP_NOT) begin
            if (word_cnt < 1) err_seen = 1'b1;
            else words[word_cnt-1] = ~words[word_cnt-1];
          end else if (word_cnt < 2) begin
            err_seen = 1'b1;
          end else begin
            a = words[word_cnt-2];
            b = words[word_cnt-1];
            case (op)
              OP_OR:    w = a | b;
              OP_AND:   w = a & b;
              OP_IMPL:  w = ~a | b;
              OP_EQUIV: w = ~(a ^ b);
              OP_XOR:   w = a ^ b;
              OP_NAND:  w = ~(a & b);
              default:  w = ~(a | b);
            endcase
            words[word_cnt-2] = w;
            word_cnt--;
          end
        end
      end
      KIND_OPER: begin
        if (op_cnt >= SDEPTH) begin
          err_seen = 1'b1;
        end else begin
          op_stk[op_cnt] = op_t'(opc);
          op_cnt++;
        end
      end
      default: ;
    endcase
    // Emit the masked top word and clear on the last token
    if (last) begin
      if (word_cnt == 0) begin
        err_seen = 1'b1;
        w = '0;
      end else begin
        w = words[word_cnt-1];
      end
      mask = (neff >= MAX_VARS) ? {TT_W{1'b1}} : ((64'd1 << (1 << neff)) - 64'd1);
      r.tt  = w & mask;
      r.err = err_seen;
      due_tables.push_back(r);
      word_cnt = 0;
      op_cnt   = 0;
      err_seen = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: predict on input transfers, check on result transfers
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    table_res_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        nvars = cfg_data;
        cfg_taken++;
      end
      if (in_tvalid && in_tready) begin
        eval_token(in_tuser, in_tdata[2:0], in_tdata[3], in_tdata[6:4], in_tlast);
        tok_taken++;
      end
      if (out_tvalid && out_tready) begin
        res_taken++;
        if (due_tables.size() == 0) begin
          flag_fault("unexpected result, truth_table", '0, out_tdata);
        end else begin
          want = due_tables.pop_front();
          if (out_tdata !== want.tt)
            flag_fault("truth_table", want.tt, out_tdata);
          if (out_tuser !== want.err)
            flag_fault("error", TT_W'(want.err), TT_W'(out_tuser));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: tokens and num_vars writes from the pending queue
  // ---------------------------------------------------------------------------
  int tx_gap  = 0;
  int tx_calm = 0;
  int quiet   = 0;

  always @(negedge clk) begin
    stim_t cur;
    logic  tok_busy;
    logic  cfg_busy;
    if (rst_n) begin
      tok_busy = in_tvalid && (tok_taken != tok_issued);
      cfg_busy = cfg_valid && (cfg_taken != cfg_issued);
      // Count idle cycles with no result outstanding
      if (due_tables.size() != 0 || tok_busy) quiet = 0;
      else if (quiet < 64) quiet = quiet + 1;
      if (tok_busy || cfg_busy) begin
        // hold the current transfer
      end else if (tx_gap > 0) begin
        tx_gap = tx_gap - 1;
        in_tvalid <= 1'b0;
        cfg_valid <= 1'b0;
      end else if (pending.size() == 0) begin
        in_tvalid <= 1'b0;
        cfg_valid <= 1'b0;
      end else begin
        cur = pending[0];
        if (cur.is_cfg) begin
          // Write num_vars only once the block has drained
          in_tvalid <= 1'b0;
          if (quiet >= SETTLE) begin
            void'(pending.pop_front());
            cfg_data  <= cur.cfg_val;
            cfg_valid <= 1'b1;
            cfg_issued++;
            quiet = 0;
          end else begin
            cfg_valid <= 1'b0;
          end
        end else begin
          void'(pending.pop_front());
          in_tdata  <= {1'b0, cur.opc, cur.cval, cur.vidx};
          in_tuser  <= cur.kind;
          in_tlast  <= cur.last;
          in_tvalid <= 1'b1;
          cfg_valid <= 1'b0;
          tok_issued++;
          quiet = 0;
          // Draw the gap before the next item, with occasional gapless runs
          if (tx_calm > 0) begin
            tx_calm--;
            tx_gap = 0;
          end else if ($urandom_range(19, 0) == 0) begin
            tx_calm = $urandom_range(50, 15);
            tx_gap  = 0;
          end else begin
            tx_gap = $urandom_range(11, 0);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: stall a random number of cycles per result
  // ---------------------------------------------------------------------------
  int rx_stall = 0;
  int rx_calm  = 0;
  int rx_mark  = 0;

  always @(negedge clk) begin
    if (res_taken != rx_mark) begin
      rx_mark = res_taken;
      if (rx_calm > 0) begin
        rx_calm--;
        rx_stall = 0;
      end else if ($urandom_range(15, 0) == 0) begin
        rx_calm  = $urandom_range(20, 5);
        rx_stall = 0;
      end else begin
        rx_stall = $urandom_range(11, 0);
      end
    end
    out_tready <= (rx_stall == 0);
    if (rx_stall > 0 && out_tvalid) rx_stall = rx_stall - 1;
  end

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------
  function automatic stim_t mk(input logic [2:0] k, input logic [2:0] v,
                               input logic c, input logic [2:0] o);
    stim_t t;
    t         = '0;
    t.kind    = k;
    t.vidx    = v;
    t.cval    = c;
    t.opc     = o;
    return t;
  endfunction

  // Token of a given kind with random don't-care fields
  function automatic stim_t any_tok(input logic [2:0] k);
    logic [2:0] v;
    logic [2:0] o;
    logic       c;
    v = 3'($urandom_range(7, 0));
    o = 3'($urandom_range(7, 0));
    c = 1'($urandom_range(1, 0));
    return mk(k, v, c, o);
  endfunction

  task automatic add_cfg(input logic [2:0] v);
    stim_t t;
    t         = '0;
    t.is_cfg  = 1'b1;
    t.cfg_val = v;
    pending.push_back(t);
  endtask

  // Move the draft sequence to the pending queue, marking its final token
  task automatic commit_draft();
    stim_t t;
    for (int i = 0; i < draft.size(); i++) begin
      t      = draft[i];
      t.last = (i == draft.size() - 1);
      live_cnt++;
      pending.push_back(t);
    end
    draft.delete();
  endtask

  task automatic draft_leaf(input int neff);
    stim_t t;
    int    v;
    if ($urandom_range(99, 0) < ((neff > 0) ? 80 : 15)) begin
      t = any_tok(KIND_VAR);
      if (neff == 0 || $urandom_range(99, 0) < 6) begin
        do v = $urandom_range(7, 0); while (v >= 1 && v <= neff);
      end else begin
        v = $urandom_range(neff, 1);
      end
      t.vidx = 3'(v);
    end else begin
      t = any_tok(KIND_CONST);
    end
    draft.push_back(t);
  endtask

  // Expand a random well-formed formula without recursion
  task automatic draft_formula(input int neff, input int depth);
    int    plan[$];
    int    node;
    int    pick;
    int    o;
    stim_t t;
    plan.push_back(depth);
    while (plan.size() > 0) begin
      node = plan.pop_front();
      if (node == PLAN_OPEN) begin
        draft.push_back(any_tok(KIND_OPEN));
      end else if (node == PLAN_CLOSE) begin
        draft.push_back(any_tok(KIND_CLOSE));
      end else if (node <= PLAN_OPER) begin
        t     = any_tok(KIND_OPER);
        t.opc = 3'(PLAN_OPER - node);
        draft.push_back(t);
      end else begin
        pick = $urandom_range(99, 0);
        if (node == 0 || pick < 25) begin
          draft_leaf(neff);
        end else if (pick < 45) begin
          plan.push_front(PLAN_CLOSE);
          plan.push_front(node - 1);
          plan.push_front(PLAN_OPER - int'(OP_NOT));
          plan.push_front(PLAN_OPEN);
        end else begin
          o = $urandom_range(6, 0);
          plan.push_front(PLAN_CLOSE);
          plan.push_front($urandom_range(node - 1, 0));
          plan.push_front(PLAN_OPER - o);
          plan.push_front($urandom_range(node - 1, 0));
          plan.push_front(PLAN_OPEN);
        end
      end
    end
  endtask

  // Break a drafted formula: drop, replace or insert one token
  task automatic mangle_draft();
    int idx;
    idx = $urandom_range(draft.size() - 1, 0);
    case ($urandom_range(2, 0))
      0: if (draft.size() > 1) draft.delete(idx);
      1: draft[idx] = any_tok(3'($urandom_range(7, 0)));
      default: draft.insert(idx, any_tok(3'($urandom_range(7, 0))));
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Sequence, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int phase_nv[10];
    int neff;
    int start;
    int pick;
    int reps;
    phase_nv = '{3, 0, 7, 1, 6, 2, 5, 4, 7, 6};

    // Directed: reset num_vars of zero, constant and empty-at-end
    draft.push_back(mk(KIND_CONST, 3'd0, 1'b1, 3'd0));
    commit_draft();
    draft.push_back(mk(KIND_SPARE, 3'd0, 1'b0, 3'd0));
    commit_draft();

    // Directed: chain through every operator at the full variable count
    add_cfg(3'(MAX_VARS));
    draft.push_back(mk(KIND_OPEN, 3'd0, 1'b0, 3'd0));
    draft.push_back(mk(KIND_VAR, 3'd1, 1'b0, 3'd0));
    for (int o = 0; o < 7; o++) begin
      draft.push_back(mk(KIND_OPER, 3'd0, 1'b0, 3'(o)));
      draft.push_back(mk(KIND_VAR, 3'((o + 1) % MAX_VARS + 1), 1'b0, 3'd0));
      draft.push_back(mk(KIND_CLOSE, 3'd0, 1'b0, 3'd0));
    end
    draft.push_back(mk(KIND_OPER, 3'd0, 1'b0, OP_NOT));
    draft.push_back(mk(KIND_CLOSE, 3'd0, 1'b0, 3'd0));
    commit_draft();

    // Directed: bad variable, close without operator, too few values
    draft.push_back(mk(KIND_VAR, 3'd0, 1'b0, 3'd0));
    commit_draft();
    draft.push_back(mk(KIND_CLOSE, 3'd7, 1'b1, 3'd7));
    commit_draft();
    draft.push_back(mk(KIND_OPER, 3'd0, 1'b0, OP_AND));
    draft.push_back(mk(KIND_CLOSE, 3'd0, 1'b0, 3'd0));
    draft.push_back(mk(KIND_CONST, 3'd0, 1'b1, 3'd0));
    commit_draft();

    // Random phases, one num_vars setting each
    foreach (phase_nv[p]) begin
      add_cfg(3'(phase_nv[p]));
      neff  = (phase_nv[p] > MAX_VARS) ? MAX_VARS : phase_nv[p];
      start = live_cnt;
      while (live_cnt - start < PHASE_ITEMS) begin
        pick = $urandom_range(99, 0);
        if (pick < 64) begin
          draft_formula(neff, $urandom_range(4, 0));
        end else if (pick < 76) begin
          draft_formula(neff, $urandom_range(3, 1));
          mangle_draft();
        end else if (pick < 86) begin
          reps = $urandom_range(8, 1);
          repeat (reps) draft.push_back(any_tok(3'($urandom_range(7, 0))));
        end else if (pick < 91) begin
          // Leftover values below the formula
          reps = $urandom_range(3, 1);
          repeat (reps) draft_leaf(neff);
          draft_formula(neff, $urandom_range(3, 0));
        end else if (pick < 93) begin
          // Value stack overflow
          reps = $urandom_range(SDEPTH + 4, SDEPTH - 2);
          repeat (reps) draft_leaf(neff);
        end else if (pick < 95) begin
          // Operator stack overflow
          reps = $urandom_range(SDEPTH + 4, SDEPTH - 2);
          repeat (reps) draft.push_back(any_tok(KIND_OPER));
          draft_leaf(neff);
        end else begin
          // Ignored kinds sprinkled into a formula
          draft_formula(neff, $urandom_range(3, 1));
          reps = $urandom_range(3, 1);
          repeat (reps)
            draft.insert($urandom_range(draft.size() - 1, 0),
                         any_tok(3'($urandom_range(7, 5))));
        end
        commit_draft();
      end
    end

    // Reset
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Drain
    while (pending.size() != 0 || tok_taken != tok_issued || cfg_taken != cfg_issued)
      @(posedge clk);
    while (due_tables.size() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);
    if (due_tables.size() != 0)
      flag_fault("missing results", TT_W'(due_tables.size()), '0);

    if (fault_cnt == 0) begin
      $display("** boolean_formula_truth_table: PASSED **");
    end else begin
      $display("** boolean_formula_truth_table: FAILED **");
    end
    $finish;
  end

endmodule
